/* src/dhf_pkg.sv */
// Package: payload and stage types for the double to IBM hex float converter.
`timescale 1ns / 1ps
package dhf_pkg;

    localparam logic [23:0] MANT_MAX  = 24'd16777215;
    localparam logic [23:0] MANT_RENORM = 24'h100000;
    localparam logic [6:0]  EXP_MAX   = 7'd127;
    localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
    localparam logic [10:0] TINY_LIMIT = 11'd731;  // at or below: all bits shifted out
    localparam logic [9:0]  LOW_SHIFT_BASE = 10'd795;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        round_mode;
    } in_t;

    typedef struct packed {
        logic [7:0]  exponent_byte;
        logic [23:0] mantissa;
        logic        overflow;
    } out_t;

    // after decode
    typedef struct packed {
        logic        zero;
        logic        special;   // inf/nan or exponent too large
        logic        tiny;      // every significand bit below the point
        logic        neg;
        logic        round_mode;
        logic [6:0]  iexp;
        logic [5:0]  sh;
        logic [52:0] sig;
    } s1_t;

    // after alignment shift
    typedef struct packed {
        logic        zero;
        logic        special;
        logic        neg;
        logic        round_mode;
        logic [6:0]  iexp;
        logic [23:0] q;
        logic        half;
    } s2_t;

endpackage

/* src/dhf_decode.sv */
// Decode stage: classify the double, derive hex exponent and right shift.
`timescale 1ns / 1ps
module dhf_decode (
    input  dhf_pkg::in_t din,
    output dhf_pkg::s1_t dout
);
    import dhf_pkg::*;

    logic [10:0]        e;
    logic [51:0]        frac;
    logic signed [11:0] ebin;
    logic signed [11:0] fl;
    logic signed [11:0] iexp_unc;
    logic               low;
    logic [9:0]         low_sh;

    always_comb
    begin
        e        = din.value_bits[62:52];
        frac     = din.value_bits[51:0];
        ebin     = $signed({1'b0, e}) - 12'sd1023;
        fl       = ebin >>> 2;
        iexp_unc = fl + 12'sd65;
        low      = (e == 11'd0) || (iexp_unc < 12'sd0);
        low_sh   = LOW_SHIFT_BASE - e[9:0];

        dout.zero       = (e == 11'd0) && (frac == 52'd0);
        dout.special    = (e == EXP_SPECIAL) || (iexp_unc > 12'sd127);
        dout.tiny       = (e == 11'd0) || (e <= TINY_LIMIT);
        dout.neg        = din.value_bits[63];
        dout.round_mode = din.round_mode;
        dout.iexp       = low ? 7'd0 : iexp_unc[6:0];
        // normal range: shift is 32 minus the low two bits of the binary exponent
        dout.sh         = low ? low_sh[5:0] : (6'd32 - {4'd0, ebin[1:0]});
        dout.sig        = {(e != 11'd0), frac};
    end
endmodule

/* src/dhf_align.sv */
// Align stage: shift the significand down to 24 bits and pick the round bit.
`timescale 1ns / 1ps
module dhf_align (
    input  dhf_pkg::s1_t din,
    output dhf_pkg::s2_t dout
);
    import dhf_pkg::*;

    logic [63:0] wide;
    logic [63:0] shifted;
    logic [63:0] half_vec;

    always_comb
    begin
        wide     = {11'd0, din.sig};
        shifted  = wide >> din.sh;
        half_vec = wide >> (din.sh - 6'd1);

        dout.zero       = din.zero;
        dout.special    = din.special;
        dout.neg        = din.neg;
        dout.round_mode = din.round_mode;
        dout.iexp       = din.iexp;
        dout.q          = din.tiny ? 24'd0 : shifted[23:0];
        dout.half       = din.tiny ? 1'b0 : half_vec[0];
    end
endmodule

/* src/dhf_round.sv */
// Round stage: apply rounding, renormalize on carry out, pack the result.
`timescale 1ns / 1ps
module dhf_round (
    input  dhf_pkg::s2_t  din,
    output dhf_pkg::out_t dout
);
    import dhf_pkg::*;

    logic        inc;
    logic [24:0] qs;
    logic        carry;

    always_comb
    begin
        inc   = din.round_mode ? din.half : din.neg;
        qs    = {1'b0, din.q} + {24'd0, inc};
        carry = qs[24];

        dout.exponent_byte = 8'd0;
        dout.mantissa      = 24'd0;
        dout.overflow      = 1'b0;
        if (din.zero)
        begin
            dout.overflow = 1'b0;
        end
        else if (din.special || (carry && (din.iexp == EXP_MAX)))
        begin
            dout.overflow = 1'b1;
        end
        else if (carry)
        begin
            // all ones rounded up: one hex digit higher, mantissa exactly 1/16
            dout.exponent_byte = {din.neg, din.iexp + 7'd1};
            dout.mantissa      = MANT_RENORM;
        end
        else
        begin
            dout.exponent_byte = {din.neg, din.iexp};
            dout.mantissa      = qs[23:0] & MANT_MAX;
        end
    end
endmodule

/* src/double_to_ibm_hex_float.sv */
// Top level: three-stage pipelined binary64 to IBM hex float converter.
//
//  channel | signals                        | transfer when
//  --------+--------------------------------+------------------------
//  value   | value_valid, value_stall, value | valid && !stall
//  code    | code_valid, code_stall, code    | valid && !stall
//
// One value is taken every clock while value_stall is low. Stages: decode,
// alignment shift, round/pack, each ending in a register. rst_n clears the
// stage valid bits only.
// Any stage holding data advances only when the one after it can take it,
// so a stall on code backs up into value_stall without loss.
`timescale 1ns / 1ps
module double_to_ibm_hex_float (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          value_valid,
    output logic          value_stall,
    input  dhf_pkg::in_t  value,
    output logic          code_valid,
    input  logic          code_stall,
    output dhf_pkg::out_t code
);
    import dhf_pkg::*;

    s1_t  s1_next, s1_reg;
    s2_t  s2_next, s2_reg;
    out_t s3_next, s3_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    // load enables ripple back from the output register
    assign en3 = !v3_reg || !code_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign value_stall = !en1;
    assign code_valid  = v3_reg;
    assign code        = s3_reg;

    dhf_decode u_decode (.din(value),  .dout(s1_next));
    dhf_align  u_align  (.din(s1_reg), .dout(s2_next));
    dhf_round  u_round  (.din(s2_reg), .dout(s3_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= value_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
    end
endmodule
